>>> rtl/cdch_pkg.sv
// Shared constants, types and the arctangent table of the concentric disk mapping.
`timescale 1ns / 1ps
package cdch_pkg;

  localparam int IN_FRAC_BITS  = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int SW            = IN_FRAC_BITS + 2;
  localparam int RW            = IN_FRAC_BITS + 1;
  localparam int QW            = 31;
  localparam int DIV_N         = QW;
  localparam int SQRT_N        = 16;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam logic signed [SW-1:0] S_ONE   = SW'(2 ** IN_FRAC_BITS);
  localparam logic signed [31:0]   K_Q30   = 32'sd652032874;
  localparam logic [29:0]          PI4_Q30 = 30'd843314857;

  typedef enum logic [1:0] {
    QUAD_RIGHT  = 2'd0,
    QUAD_TOP    = 2'd1,
    QUAD_LEFT   = 2'd2,
    QUAD_BOTTOM = 2'd3
  } quad_e;

  typedef struct packed {
    logic          center;
    quad_e         quad;
    logic          neg;
    logic [RW-1:0] r;
    logic [RW-1:0] nm;
  } cls_t;

  function automatic logic signed [31:0] atan_q30(input int unsigned i);
    logic signed [31:0] v;
    unique case (i)
      0:  v = 32'sd843314856;
      1:  v = 32'sd497837829;
      2:  v = 32'sd263043836;
      3:  v = 32'sd133525158;
      4:  v = 32'sd67021686;
      5:  v = 32'sd33543515;
      6:  v = 32'sd16775850;
      7:  v = 32'sd8388437;
      8:  v = 32'sd4194282;
      9:  v = 32'sd2097149;
      10: v = 32'sd1048575;
      11: v = 32'sd524287;
      12: v = 32'sd262143;
      13: v = 32'sd131071;
      14: v = 32'sd65535;
      15: v = 32'sd32767;
      16: v = 32'sd16383;
      17: v = 32'sd8191;
      18: v = 32'sd4095;
      19: v = 32'sd2047;
      20: v = 32'sd1023;
      21: v = 32'sd511;
      22: v = 32'sd255;
      23: v = 32'sd127;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/cdch_if.sv
// Valid/ready channel interfaces for samples, classified requests and results.
`timescale 1ns / 1ps
interface cdch_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] u_first;
  logic [15:0] u_second;
  modport source (output valid, output u_first, output u_second, input ready);
  modport sink (input valid, input u_first, input u_second, output ready);
endinterface

interface cdch_cls_if import cdch_pkg::*; ;
  logic valid;
  logic ready;
  cls_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cdch_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] disk_x;
  logic signed [15:0] disk_y;
  logic [14:0]        hemi_z;
  modport source (output valid, output disk_x, output disk_y, output hemi_z, input ready);
  modport sink (input valid, input disk_x, input disk_y, input hemi_z, output ready);
endinterface

>>> rtl/cdch_front.sv
// Front end: maps samples to the square and picks the wedge, radius and numerator.
`timescale 1ns / 1ps
module cdch_front import cdch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdch_in_if.sink    req_i,
  cdch_cls_if.source cls_o
);

  logic signed [SW-1:0] sx, sy, r_s, num_s, nmag;
  cls_t cls_d, cls_q;
  logic vld_q;

  always_comb begin
    sx = $signed({1'b0, req_i.u_first[IN_FRAC_BITS-1:0], 1'b0}) - S_ONE;
    sy = $signed({1'b0, req_i.u_second[IN_FRAC_BITS-1:0], 1'b0}) - S_ONE;
    cls_d.center = (sx == '0) && (sy == '0);
    if (sx >= -sy) begin
      if (sx > sy) begin
        r_s = sx; num_s = sy; cls_d.quad = QUAD_RIGHT;
      end else begin
        r_s = sy; num_s = -sx; cls_d.quad = QUAD_TOP;
      end
    end else begin
      if (sx <= sy) begin
        r_s = -sx; num_s = -sy; cls_d.quad = QUAD_LEFT;
      end else begin
        r_s = -sy; num_s = sx; cls_d.quad = QUAD_BOTTOM;
      end
    end
    nmag = (num_s < 0) ? -num_s : num_s;
    cls_d.neg = num_s < 0;
    cls_d.r   = cls_d.center ? RW'(1) : r_s[RW-1:0];
    cls_d.nm  = cls_d.center ? '0 : nmag[RW-1:0];
  end

  assign req_i.ready = !vld_q || cls_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (req_i.ready) begin
      vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cls_q <= cls_d;
    end
  end

  assign cls_o.valid = vld_q;
  assign cls_o.data  = cls_q;

endmodule

>>> rtl/cdch_fifo.sv
// Short queue between the classifying front end and the arithmetic back end.
`timescale 1ns / 1ps
module cdch_fifo import cdch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdch_cls_if.sink   cls_i,
  cdch_cls_if.source cls_o
);

  cls_t mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic push, pop;

  assign cls_i.ready = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
  assign cls_o.valid = cnt_q != '0;
  assign cls_o.data  = mem_q[rd_q];
  assign push = cls_i.valid && cls_i.ready;
  assign pop  = cls_o.valid && cls_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls_i.data;
    end
  end

endmodule

>>> rtl/cdch_back.sv
// Back end pipeline: ratio divider, angle scaling, rotation, scaling and height root.
`timescale 1ns / 1ps
module cdch_back import cdch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdch_cls_if.sink   cls_i,
  cdch_out_if.source res_o
);

  localparam int PHI  = DIV_N;
  localparam int COR0 = PHI + 1;
  localparam int MUL  = COR0 + CORDIC_N;
  localparam int RND  = MUL + 1;
  localparam int SQR  = RND + 1;
  localparam int RAD  = SQR + 1;
  localparam int SQ0  = RAD + 1;
  localparam int OUTS = SQ0 + SQRT_N;
  localparam int NST  = OUTS + 1;
  localparam int PW   = 32 + RW + 1;
  localparam int SHR  = 15 + IN_FRAC_BITS;
  localparam int CW   = PW - SHR + 1;

  typedef struct packed {
    logic          center;
    quad_e         quad;
    logic          neg;
    logic [RW-1:0] r;
  } side_t;

  logic en;
  logic vld_q [NST];

  side_t side_d [MUL+1];
  side_t side_q [MUL+1];

  logic [RW-1:0] drem_d [DIV_N];
  logic [RW-1:0] drem_q [DIV_N];
  logic [QW-1:0] dquo_d [DIV_N];
  logic [QW-1:0] dquo_q [DIV_N];

  logic signed [31:0] phi_d, phi_q;
  logic signed [31:0] cx_d [CORDIC_N];
  logic signed [31:0] cx_q [CORDIC_N];
  logic signed [31:0] cy_d [CORDIC_N];
  logic signed [31:0] cy_q [CORDIC_N];
  logic signed [31:0] cz_d [CORDIC_N];
  logic signed [31:0] cz_q [CORDIC_N];

  logic signed [PW-1:0] mx_d, my_d, mx_q, my_q;

  logic signed [15:0] px_d [RND:OUTS];
  logic signed [15:0] px_q [RND:OUTS];
  logic signed [15:0] py_d [RND:OUTS];
  logic signed [15:0] py_q [RND:OUTS];

  logic [31:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic [30:0] rad_d, rad_q;
  logic [30:0] srem_d [SQRT_N];
  logic [30:0] srem_q [SQRT_N];
  logic [15:0] sres_d [SQRT_N];
  logic [15:0] sres_q [SQRT_N];
  logic [14:0] hz_d, hz_q;

  function automatic logic signed [CW-1:0] round_q15(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag, sum;
    logic [CW-1:0] m;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    sum = mag + (PW'(1) << (SHR - 1));
    m   = CW'(sum >> SHR);
    return p[PW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
    logic signed [15:0] o;
    if (v > $signed(CW'(32767))) begin
      o = 16'sd32767;
    end else if (v < -$signed(CW'(32768))) begin
      o = -16'sd32768;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

  assign en          = !vld_q[NST-1] || res_o.ready;
  assign cls_i.ready = en;

  always_comb begin
    logic [RW:0]         rem2;
    logic                qb;
    logic [2*QW-2:0]     prod;
    logic [QW-1:0]       pm;
    logic signed [CW-1:0] rx, ry, ox, oy;
    logic signed [32:0]  t;
    logic [33:0]         trial;
    int unsigned         b;

    side_d[0] = '{center: cls_i.data.center, quad: cls_i.data.quad,
                  neg: cls_i.data.neg, r: cls_i.data.r};
    for (int k = 1; k <= MUL; k++) begin
      side_d[k] = side_q[k-1];
    end

    qb        = cls_i.data.nm >= cls_i.data.r;
    drem_d[0] = cls_i.data.nm - (qb ? cls_i.data.r : '0);
    dquo_d[0] = QW'(qb);
    for (int k = 1; k < DIV_N; k++) begin
      rem2      = {drem_q[k-1], 1'b0};
      qb        = rem2 >= {1'b0, side_q[k-1].r};
      drem_d[k] = RW'(rem2 - (qb ? {1'b0, side_q[k-1].r} : '0));
      dquo_d[k] = {dquo_q[k-1][QW-2:0], qb};
    end

    prod  = {30'b0, dquo_q[DIV_N-1]} * {QW'(0), PI4_Q30};
    prod  = prod + ((2*QW-1)'(1) << 29);
    pm    = QW'(prod >> 30);
    phi_d = side_q[DIV_N-1].neg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});

    for (int i = 0; i < CORDIC_N; i++) begin
      logic signed [31:0] xi, yi, zi;
      xi = (i == 0) ? K_Q30 : cx_q[i-1];
      yi = (i == 0) ? 32'sd0 : cy_q[i-1];
      zi = (i == 0) ? phi_q : cz_q[i-1];
      if (zi >= 0) begin
        cx_d[i] = xi - (yi >>> i);
        cy_d[i] = yi + (xi >>> i);
        cz_d[i] = zi - atan_q30(i);
      end else begin
        cx_d[i] = xi + (yi >>> i);
        cy_d[i] = yi - (xi >>> i);
        cz_d[i] = zi + atan_q30(i);
      end
    end

    mx_d = PW'(cx_q[CORDIC_N-1]) * $signed({1'b0, side_q[MUL-1].r});
    my_d = PW'(cy_q[CORDIC_N-1]) * $signed({1'b0, side_q[MUL-1].r});

    rx = round_q15(mx_q);
    ry = round_q15(my_q);
    unique case (side_q[MUL].quad)
      QUAD_RIGHT:  begin ox = rx;  oy = ry;  end
      QUAD_TOP:    begin ox = -ry; oy = rx;  end
      QUAD_LEFT:   begin ox = -rx; oy = -ry; end
      QUAD_BOTTOM: begin ox = ry;  oy = -rx; end
      default:     begin ox = rx;  oy = ry;  end
    endcase
    px_d[RND] = side_q[MUL].center ? 16'sd0 : sat16(ox);
    py_d[RND] = side_q[MUL].center ? 16'sd0 : sat16(oy);
    for (int k = RND + 1; k <= OUTS; k++) begin
      px_d[k] = px_q[k-1];
      py_d[k] = py_q[k-1];
    end

    sqx_d = 32'(px_q[RND] * px_q[RND]);
    sqy_d = 32'(py_q[RND] * py_q[RND]);

    t     = $signed(33'(1) << 30) - $signed({1'b0, sqx_q}) - $signed({1'b0, sqy_q});
    rad_d = (t <= 0) ? '0 : t[30:0];

    for (int j = 0; j < SQRT_N; j++) begin
      logic [30:0] ri;
      logic [15:0] si;
      b     = SQRT_N - 1 - j;
      ri    = (j == 0) ? rad_q : srem_q[j-1];
      si    = (j == 0) ? '0 : sres_q[j-1];
      trial = (34'(si) << (b + 1)) + (34'(1) << (2 * b));
      if ({3'b0, ri} >= trial) begin
        srem_d[j] = 31'({3'b0, ri} - trial);
        sres_d[j] = si | (16'(1) << b);
      end else begin
        srem_d[j] = ri;
        sres_d[j] = si;
      end
    end

    hz_d = (sres_q[SQRT_N-1] > 16'd32767) ? 15'h7fff : sres_q[SQRT_N-1][14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= cls_i.valid;
      for (int k = 1; k < NST; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_d;
      drem_q <= drem_d;
      dquo_q <= dquo_d;
      phi_q  <= phi_d;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      cz_q   <= cz_d;
      mx_q   <= mx_d;
      my_q   <= my_d;
      px_q   <= px_d;
      py_q   <= py_d;
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      rad_q  <= rad_d;
      srem_q <= srem_d;
      sres_q <= sres_d;
      hz_q   <= hz_d;
    end
  end

  assign res_o.valid  = vld_q[NST-1];
  assign res_o.disk_x = px_q[OUTS];
  assign res_o.disk_y = py_q[OUTS];
  assign res_o.hemi_z = hz_q;

`ifndef SYNTHESIS
  logic [33:0] chk_sum;
  assign chk_sum = 34'(32'(res_o.disk_x * res_o.disk_x)) +
                   34'(32'(res_o.disk_y * res_o.disk_y)) +
                   34'({15'b0, res_o.hemi_z} * {15'b0, res_o.hemi_z});

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_N-1] |-> drem_q[DIV_N-1] < side_q[DIV_N-1].r)
    else $error("Divider remainder is not below the radius.");

  a_center_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.disk_x == 16'sd0 && res_o.disk_y == 16'sd0
      |-> res_o.hemi_z == 15'h7fff)
    else $error("Height at the disk center is not full scale.");

  a_unit_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.hemi_z != '0 |-> chk_sum <= (34'(1) << 30))
    else $error("Result point lies outside the unit sphere.");
`endif

endmodule

>>> rtl/concentric_disk_cosine_hemisphere.sv
// Throughput: one request per cycle; the 31-step divider, 16-stage rotation and
// 16-step root are fully pipelined and the whole back end stalls together.
// A two-entry queue lets the front end keep accepting while the result waits.
// Reset is asynchronous and active low; it clears all valid and queue state.
`timescale 1ns / 1ps
module concentric_disk_cosine_hemisphere (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdch_in_if.sink    req_i,
  cdch_out_if.source res_o
);

  cdch_cls_if front_to_queue ();
  cdch_cls_if queue_to_back ();

  cdch_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cls_o  (front_to_queue)
  );

  cdch_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cls_i  (front_to_queue),
    .cls_o  (queue_to_back)
  );

  cdch_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cls_i  (queue_to_back),
    .res_o  (res_o)
  );

endmodule

>>> tb/concentric_disk_cosine_hemisphere_test.sv
// Self-checking testbench for the concentric disk mapping with hemisphere height.
`timescale 1ns / 1ps
module concentric_disk_cosine_hemisphere_test;
  import cdch_pkg::*;

  typedef struct packed {
    logic [15:0] u_first;
    logic [15:0] u_second;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] disk_x;
    logic signed [15:0] disk_y;
    logic [14:0]        hemi_z;
  } point_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 600;

  logic clk_i;
  logic rst_ni;

  cdch_in_if  req_if ();
  cdch_out_if res_if ();

  concentric_disk_cosine_hemisphere dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  sample_t pending_samples[$];
  point_t  expected_points[$];
  int      mismatches;
  int      accepted_reqs;
  int      checked_points;
  int      idle_cycles;
  int      hold_off_cycles;
  int      send_gap;
  int      recv_gap;
  bit      hold_request;
  bit      hold_started;
  bit      pause_until_empty;
  bit      stimulus_done;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint round_away(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_sqrt(longint t);
    longint root;
    longint bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > t) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (t >= root + bitv) begin
        t = t - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  function automatic point_t map_to_disk(sample_t s);
    longint sx, sy, r, num, nm, qm, pm, ang, cx, cy, dx, dy, px, py, rad, hz;
    longint rx, ry;
    quad_e  quad;
    point_t p;
    sx = 2 * longint'(s.u_first) - 65536;
    sy = 2 * longint'(s.u_second) - 65536;
    px = 0;
    py = 0;
    if (!(sx == 0 && sy == 0)) begin
      if (sx >= -sy) begin
        if (sx > sy) begin
          r = sx; num = sy; quad = QUAD_RIGHT;
        end else begin
          r = sy; num = -sx; quad = QUAD_TOP;
        end
      end else begin
        if (sx <= sy) begin
          r = -sx; num = -sy; quad = QUAD_LEFT;
        end else begin
          r = -sy; num = sx; quad = QUAD_BOTTOM;
        end
      end
      nm = (num < 0) ? -num : num;
      qm = (r > 0) ? (nm << 30) / r : 0;
      if (qm > (longint'(1) << 30)) qm = longint'(1) << 30;
      pm = (qm * longint'(PI4_Q30) + (longint'(1) << 29)) >>> 30;
      ang = (num < 0) ? -pm : pm;
      rx = K_Q30;
      ry = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        dx = floor_shift(ry, i);
        dy = floor_shift(rx, i);
        if (ang >= 0) begin
          rx = rx - dx; ry = ry + dy; ang = ang - atan_q30(i);
        end else begin
          rx = rx + dx; ry = ry - dy; ang = ang + atan_q30(i);
        end
      end
      cx = round_away(rx * r, 31);
      cy = round_away(ry * r, 31);
      case (quad)
        QUAD_RIGHT: begin px = cx;  py = cy;  end
        QUAD_TOP:   begin px = -cy; py = cx;  end
        QUAD_LEFT:  begin px = -cx; py = -cy; end
        default:    begin px = cy;  py = -cx; end
      endcase
      px = clamp16(px);
      py = clamp16(py);
    end
    rad = (longint'(1) << 30) - px * px - py * py;
    hz = (rad <= 0) ? 0 : int_sqrt(rad);
    if (hz > 32767) hz = 32767;
    p.disk_x = px[15:0];
    p.disk_y = py[15:0];
    p.hemi_z = hz[14:0];
    return p;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t make_sample(logic [15:0] a, logic [15:0] b);
    sample_t s;
    s.u_first = a;
    s.u_second = b;
    return s;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Directed corners, then mostly random samples with some near the diagonals and center.
  initial begin
    logic [15:0] a, b;
    int roll;
    stimulus_done = 1'b0;
    pause_until_empty = 1'b0;
    hold_request = 1'b0;
    pending_samples.push_back(make_sample(16'h8000, 16'h8000));
    pending_samples.push_back(make_sample(16'h0000, 16'h0000));
    pending_samples.push_back(make_sample(16'hFFFF, 16'hFFFF));
    pending_samples.push_back(make_sample(16'h0000, 16'hFFFF));
    pending_samples.push_back(make_sample(16'hFFFF, 16'h0000));
    pending_samples.push_back(make_sample(16'h0000, 16'h8000));
    pending_samples.push_back(make_sample(16'hFFFF, 16'h8000));
    pending_samples.push_back(make_sample(16'h8000, 16'h0000));
    pending_samples.push_back(make_sample(16'h8000, 16'hFFFF));
    pending_samples.push_back(make_sample(16'h8001, 16'h8000));
    pending_samples.push_back(make_sample(16'h8000, 16'h8001));
    pending_samples.push_back(make_sample(16'h7FFF, 16'h8000));
    pending_samples.push_back(make_sample(16'h8000, 16'h7FFF));
    pending_samples.push_back(make_sample(16'hC000, 16'hC000));
    pending_samples.push_back(make_sample(16'h4000, 16'hC000));
    pending_samples.push_back(make_sample(16'h4000, 16'h4000));
    pending_samples.push_back(make_sample(16'hC000, 16'h4000));
    pending_samples.push_back(make_sample(16'hAAAA, 16'h5555));
    pending_samples.push_back(make_sample(16'h5555, 16'hAAAA));
    pending_samples.push_back(make_sample(16'h0001, 16'hFFFE));
    wait (rst_ni);
    wait (pending_samples.size() == 0);
    for (int n = 0; n < 640; n++) begin
      if (n == 150) begin
        // Starve the result side while requests keep coming, to fill the pipeline.
        hold_request = 1'b1;
      end
      if (n == 400) begin
        wait (pending_samples.size() == 0);
        @(negedge clk_i);
        pause_until_empty = 1'b1;
        do @(negedge clk_i); while (expected_points.size() != 0 || req_if.valid);
        pause_until_empty = 1'b0;
      end
      roll = $urandom_range(0, 9);
      a = 16'($urandom_range(0, 16'hFFFF));
      b = 16'($urandom_range(0, 16'hFFFF));
      if (roll == 0) begin
        b = a + 16'($urandom_range(0, 2)) - 16'd1;
      end else if (roll == 1) begin
        b = 16'hFFFF - a + 16'($urandom_range(0, 2));
      end else if (roll == 2) begin
        a = 16'h8000 + 16'($urandom_range(0, 6)) - 16'd3;
        b = 16'h8000 + 16'($urandom_range(0, 6)) - 16'd3;
      end
      pending_samples.push_back(make_sample(a, b));
      if (pending_samples.size() > 8) wait (pending_samples.size() <= 8);
    end
    stimulus_done = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.u_first <= 16'd0;
      req_if.u_second <= 16'd0;
      send_gap <= 0;
      accepted_reqs <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_points.push_back(map_to_disk(make_sample(req_if.u_first, req_if.u_second)));
        accepted_reqs <= accepted_reqs + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_samples.size() != 0 && !pause_until_empty) begin
          sample_t s;
          s = pending_samples.pop_front();
          req_if.valid <= 1'b1;
          req_if.u_first <= s.u_first;
          req_if.u_second <= s.u_second;
          send_gap <= pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_cycles <= 0;
      hold_started <= 1'b0;
    end else if (hold_request && !hold_started) begin
      hold_off_cycles <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap <= 0;
      mismatches <= 0;
      checked_points <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        point_t p;
        checked_points <= checked_points + 1;
        if (expected_points.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result x=%0d y=%0d z=%0d",
                     res_if.disk_x, res_if.disk_y, res_if.hemi_z);
          mismatches <= mismatches + 1;
        end else begin
          p = expected_points.pop_front();
          if (p.disk_x !== res_if.disk_x || p.disk_y !== res_if.disk_y ||
              p.hemi_z !== res_if.hemi_z) begin
            if (mismatches < 10)
              $display("Mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       p.disk_x, p.disk_y, p.hemi_z,
                       res_if.disk_x, res_if.disk_y, res_if.hemi_z);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        res_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.", expected_points.size());
        $display("** concentric_disk_cosine_hemisphere: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    wait (rst_ni);
    do @(negedge clk_i);
    while (!(stimulus_done && pending_samples.size() == 0 && !req_if.valid &&
             expected_points.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d sample pairs and checked %0d disk points, with corners, diagonals,",
             accepted_reqs, checked_points);
    $display("the center, random gaps and a long output stall; %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("** concentric_disk_cosine_hemisphere: PASSED **");
    end else begin
      $display("** concentric_disk_cosine_hemisphere: FAILED **");
    end
    $finish;
  end

endmodule
